// ----- rtl/mft_pkg.sv -----
// ----------------------------------------------------------------------------
// mft_pkg: shared types and constants of the multi-turn tracker
// Field widths, register codes, reset values and the item structs that move
// between the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package mft_pkg;

	// Frame fields
	localparam int ID_W       = 11;
	localparam int PAYLOAD_W  = 56;
	localparam int BYTE_W     = 8;
	localparam int WORD_W     = 16;

	// Payload byte positions, byte 0 in the top bits
	localparam int ENC_LSB    = 40;
	localparam int SPEED_LSB  = 24;
	localparam int CURR_LSB   = 8;
	localparam int TEMP_LSB   = 0;

	// Slot window and per-slot store
	localparam int SLOTS_PER_BUS = 8;
	localparam int SLOT_W        = 3;
	localparam int CNT_W         = 4;
	localparam int IDX_W         = SLOT_W + 1;
	localparam int STORE_DEPTH   = 1 << IDX_W;

	// Encoder and turn count
	localparam int ENC_W          = 13;
	localparam int ENCODER_COUNTS = 1 << ENC_W;
	localparam logic [ENC_W-1:0] ENC_MAX = {ENC_W{1'b1}};
	localparam logic signed [ENC_W:0] HALF_TURN = (ENC_W+1)'(ENCODER_COUNTS / 2);
	localparam int TURN_W         = 24;
	localparam int COUNT_W        = TURN_W + ENC_W;

	// Scaling: unsigned Q0.24 scale, signed Q31.16 angle
	localparam int SCALE_W     = 24;
	localparam int SCALE_FRAC  = 24;
	localparam int ANGLE_W     = 48;
	localparam int ANGLE_FRAC  = 16;
	localparam int DROP_W      = SCALE_FRAC - ANGLE_FRAC;
	localparam int MAG_LO_W    = 24;
	localparam int MAG_HI_W    = COUNT_W - MAG_LO_W;
	localparam int PROD_LO_W   = MAG_LO_W + SCALE_W;
	localparam int PROD_HI_W   = MAG_HI_W + SCALE_W;
	localparam int HI_KEEP_W   = ANGLE_W - ANGLE_FRAC;
	localparam logic [ANGLE_W:0] ROUND_BIAS  = (ANGLE_W+1)'(1) << (DROP_W - 1);
	localparam logic [ANGLE_W:0] ANGLE_POS_MAX = {2'b00, {(ANGLE_W-1){1'b1}}};
	localparam logic [ANGLE_W:0] ANGLE_NEG_MAG = {2'b01, {(ANGLE_W-1){1'b0}}};

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUS0_BASE    = 3'd0,
		REG_BUS0_COUNT   = 3'd1,
		REG_BUS1_BASE    = 3'd2,
		REG_BUS1_COUNT   = 3'd3,
		REG_DIRECT_MASK  = 3'd4,
		REG_GEARED_SCALE = 3'd5,
		REG_DIRECT_SCALE = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [ID_W-1:0]        bus0_base;
		logic [CNT_W-1:0]       bus0_count;
		logic [ID_W-1:0]        bus1_base;
		logic [CNT_W-1:0]       bus1_count;
		logic [STORE_DEPTH-1:0] direct_mask;
		logic [SCALE_W-1:0]     geared_scale;
		logic [SCALE_W-1:0]     direct_scale;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		bus0_base:    ID_W'(513),
		bus0_count:   CNT_W'(4),
		bus1_base:    ID_W'(513),
		bus1_count:   CNT_W'(8),
		direct_mask:  STORE_DEPTH'(16384),
		geared_scale: SCALE_W'(38398),
		direct_scale: SCALE_W'(737370)
	};

	// Received frame as captured at the input
	typedef struct packed {
		logic                 bus;
		logic [ID_W-1:0]      id;
		logic [PAYLOAD_W-1:0] payload;
	} frame_t;

	// Unpacked result fields, carried to the output unchanged
	typedef struct packed {
		logic               bus;
		logic [SLOT_W-1:0]  slot;
		logic [ENC_W-1:0]   encoder;
		logic [WORD_W-1:0]  speed;
		logic [WORD_W-1:0]  current;
		logic [BYTE_W-1:0]  temperature;
		logic [TURN_W-1:0]  turns;
	} fields_t;

	// Item after unwrap: sign and magnitude of the count, selected scale
	typedef struct packed {
		fields_t              f;
		logic                 neg;
		logic [COUNT_W-1:0]   mag;
		logic [SCALE_W-1:0]   scale;
	} unwrap_t;

	// Item after the two partial products
	typedef struct packed {
		fields_t               f;
		logic                  neg;
		logic [PROD_HI_W-1:0]  hi;
		logic [PROD_LO_W-1:0]  lo;
	} prod_t;

endpackage

`default_nettype wire

// ----- rtl/mft_cfg.sv -----
// ----------------------------------------------------------------------------
// mft_cfg: configuration registers
// Write-only register file; an index with no register is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module mft_cfg import mft_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Write the addressed register, keep only its own bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BUS0_BASE:    cfg_q.bus0_base    <= cfg_data[ID_W-1:0];
				REG_BUS0_COUNT:   cfg_q.bus0_count   <= cfg_data[CNT_W-1:0];
				REG_BUS1_BASE:    cfg_q.bus1_base    <= cfg_data[ID_W-1:0];
				REG_BUS1_COUNT:   cfg_q.bus1_count   <= cfg_data[CNT_W-1:0];
				REG_DIRECT_MASK:  cfg_q.direct_mask  <= cfg_data[STORE_DEPTH-1:0];
				REG_GEARED_SCALE: cfg_q.geared_scale <= cfg_data[SCALE_W-1:0];
				REG_DIRECT_SCALE: cfg_q.direct_scale <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/mft_unwrap.sv -----
// ----------------------------------------------------------------------------
// mft_unwrap: slot match, unpack and turn tracking
// Matches the frame to a slot, unpacks the payload, updates the slot's
// previous reading and turn count, and forms the signed count magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module mft_unwrap import mft_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	input  frame_t  in_frame,
	output logic    in_ready,
	output logic    out_valid,
	output unwrap_t out_item,
	input  logic    out_ready
);

	logic [ENC_W-1:0]  prev_q [STORE_DEPTH];
	logic [TURN_W-1:0] turn_q [STORE_DEPTH];
	logic              v_s2;
	unwrap_t           item_s2;

	logic [ID_W-1:0]          base;
	logic [CNT_W-1:0]         cnt_raw;
	logic [CNT_W-1:0]         cnt;
	logic [ID_W:0]            id_off;
	logic                     hit;
	logic [SLOT_W-1:0]        slot;
	logic [IDX_W-1:0]         idx;
	logic [WORD_W-1:0]        enc_raw;
	logic [ENC_W-1:0]         enc;
	logic [ENC_W-1:0]         prev;
	logic [TURN_W-1:0]        turn_rd;
	logic [TURN_W-1:0]        turn_nxt;
	logic signed [ENC_W:0]    enc_diff;
	logic [COUNT_W-1:0]       counts;
	logic                     neg;
	logic                     upd_en;
	unwrap_t                  item_nxt;

	// Match the identifier against the bus window
	always_comb begin
		base    = in_frame.bus ? cfg.bus1_base : cfg.bus0_base;
		cnt_raw = in_frame.bus ? cfg.bus1_count : cfg.bus0_count;
		cnt     = (cnt_raw > CNT_W'(SLOTS_PER_BUS)) ? CNT_W'(SLOTS_PER_BUS) : cnt_raw;
		id_off  = {1'b0, in_frame.id} - {1'b0, base};
		hit     = !id_off[ID_W] && (id_off[ID_W-1:0] < ID_W'(cnt));
		slot    = id_off[SLOT_W-1:0];
		idx     = {in_frame.bus, slot};
	end

	// Clamp the reading and count a turn on a jump of half a turn or more
	always_comb begin
		enc_raw  = in_frame.payload[ENC_LSB +: WORD_W];
		enc      = (enc_raw > WORD_W'(ENC_MAX)) ? ENC_MAX : enc_raw[ENC_W-1:0];
		prev     = prev_q[idx];
		turn_rd  = turn_q[idx];
		enc_diff = signed'({1'b0, enc}) - signed'({1'b0, prev});
		priority if (enc_diff >= HALF_TURN) begin
			turn_nxt = turn_rd - TURN_W'(1);
		end else if (enc_diff <= -HALF_TURN) begin
			turn_nxt = turn_rd + TURN_W'(1);
		end else begin
			turn_nxt = turn_rd;
		end
		counts = {turn_nxt, enc};
		neg    = turn_nxt[TURN_W-1];
	end

	// Assemble the unwrapped item
	always_comb begin
		item_nxt.f.bus         = in_frame.bus;
		item_nxt.f.slot        = slot;
		item_nxt.f.encoder     = enc;
		item_nxt.f.speed       = in_frame.payload[SPEED_LSB +: WORD_W];
		item_nxt.f.current     = in_frame.payload[CURR_LSB +: WORD_W];
		item_nxt.f.temperature = in_frame.payload[TEMP_LSB +: BYTE_W];
		item_nxt.f.turns       = turn_nxt;
		item_nxt.neg           = neg;
		item_nxt.mag           = neg ? (COUNT_W'(0) - counts) : counts;
		item_nxt.scale         = cfg.direct_mask[idx] ? cfg.direct_scale : cfg.geared_scale;
	end

	assign in_ready = !v_s2 || out_ready;
	assign upd_en   = in_valid && in_ready && hit;

	// Update the slot state as a matched item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				prev_q[i] <= '0;
				turn_q[i] <= '0;
			end
		end else if (upd_en) begin
			prev_q[idx] <= enc;
			turn_q[idx] <= turn_nxt;
		end
	end

	// Advance the stage valid; drop unmatched items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en) begin
			item_s2 <= item_nxt;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

`ifndef SYNTHESIS
	a_prev_stored: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en |=> prev_q[{item_s2.f.bus, item_s2.f.slot}] == item_s2.f.encoder)
		else $error("stored reading differs from the reported one");

	a_turn_stored: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en |=> turn_q[{item_s2.f.bus, item_s2.f.slot}] == item_s2.f.turns)
		else $error("stored turn count differs from the reported one");

	a_turn_step: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en |=> (TURN_W'(item_s2.f.turns - $past(turn_rd)) == TURN_W'(0)) ||
			(TURN_W'(item_s2.f.turns - $past(turn_rd)) == TURN_W'(1)) ||
			(TURN_W'(item_s2.f.turns - $past(turn_rd)) == {TURN_W{1'b1}}))
		else $error("turn count moved by more than one turn");
`endif

endmodule

`default_nettype wire

// ----- rtl/mft_angle.sv -----
// ----------------------------------------------------------------------------
// mft_angle: angle scaling
// Multiplies the count magnitude by the scale in two partial products, then
// rounds to Q31.16, applies the sign and saturates into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mft_angle import mft_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  unwrap_t            in_item,
	output logic               in_ready,
	output logic               out_valid,
	output fields_t            out_fields,
	output logic [ANGLE_W-1:0] out_angle,
	input  logic               out_ready
);

	logic               v_s3;
	prod_t              prod_s3;
	logic               v_s4;
	fields_t            fields_s4;
	logic [ANGLE_W-1:0] angle_s4;
	logic               neg_s4;

	logic                s4_ready;
	logic                s3_load;
	logic                s4_load;
	prod_t               prod_nxt;
	logic                sat_hi;
	logic [ANGLE_W:0]    lo_rnd;
	logic [ANGLE_W:0]    mag_r;
	logic [ANGLE_W-1:0]  angle_nxt;

	assign s4_ready = !v_s4 || out_ready;
	assign in_ready = !v_s3 || s4_ready;
	assign s3_load  = in_valid && in_ready;
	assign s4_load  = v_s3 && s4_ready;

	// Form the high and low partial products
	always_comb begin
		prod_nxt.f   = in_item.f;
		prod_nxt.neg = in_item.neg;
		prod_nxt.hi  = PROD_HI_W'(in_item.mag[COUNT_W-1:MAG_LO_W]) * PROD_HI_W'(in_item.scale);
		prod_nxt.lo  = PROD_LO_W'(in_item.mag[MAG_LO_W-1:0]) * PROD_LO_W'(in_item.scale);
	end

	// Round to Q31.16, apply the sign, saturate
	always_comb begin
		sat_hi = |prod_s3.hi[PROD_HI_W-1:HI_KEEP_W];
		lo_rnd = (ANGLE_W+1)'(prod_s3.lo) + ROUND_BIAS;
		if (sat_hi) begin
			mag_r = (ANGLE_W+1)'(1) << ANGLE_W;
		end else begin
			mag_r = (ANGLE_W+1)'({prod_s3.hi[HI_KEEP_W-1:0], {ANGLE_FRAC{1'b0}}}) +
				(lo_rnd >> DROP_W);
		end
		if (!prod_s3.neg) begin
			angle_nxt = (mag_r > ANGLE_POS_MAX) ? ANGLE_POS_MAX[ANGLE_W-1:0] :
				mag_r[ANGLE_W-1:0];
		end else begin
			angle_nxt = (mag_r > ANGLE_NEG_MAG) ? ANGLE_NEG_MAG[ANGLE_W-1:0] :
				(ANGLE_W'(0) - mag_r[ANGLE_W-1:0]);
		end
	end

	// Advance the stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s3 <= in_valid;
			end
			if (s4_ready) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Hold payloads while stalled
	always_ff @(posedge clk) begin
		if (s3_load) begin
			prod_s3 <= prod_nxt;
		end
		if (s4_load) begin
			fields_s4 <= prod_s3.f;
			angle_s4  <= angle_nxt;
			neg_s4    <= prod_s3.neg;
		end
	end

	assign out_valid  = v_s4;
	assign out_fields = fields_s4;
	assign out_angle  = angle_s4;

`ifndef SYNTHESIS
	a_neg_sign: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && neg_s4 |-> angle_s4[ANGLE_W-1] || (angle_s4 == ANGLE_W'(0)))
		else $error("negative count gave a positive angle");

	a_pos_sign: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !neg_s4 |-> !angle_s4[ANGLE_W-1])
		else $error("non-negative count gave a negative angle");

	a_sat_hi: assert property (@(posedge clk) disable iff (!arst_n)
		s4_load && sat_hi |=> (angle_s4 == ANGLE_POS_MAX[ANGLE_W-1:0]) ||
			(angle_s4 == ANGLE_NEG_MAG[ANGLE_W-1:0]))
		else $error("overflowing product not saturated");
`endif

endmodule

`default_nettype wire

// ----- rtl/motor_feedback_multiturn_tracker.sv -----
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_tracker: motor feedback multi-turn tracker
// Unpacks motor feedback frames for a window of slots per bus and tracks a
// wrapped turn count and an unwrapped angle for each slot.
// ----------------------------------------------------------------------------
// Usage:
// Input channel (in_valid / in_stall): one received frame per item, with its
// bus, identifier and payload bytes 0 to 6. Output channel (out_valid /
// out_stall): one result per matched frame; a frame outside its bus window
// gives no result and leaves the slot state as it was.
// Path: an accepted item passes the input register, unwrap stage, product
// stage and output register before its result is valid.
// Throughput: one item per cycle while out_stall is low; the per-slot
// read-modify-write of the previous reading and turn count closes in the
// unwrap stage, so frames for the same slot may follow back to back.
// Stall: each stage holds its item while the next is full; with out_stall
// high the four stages fill and in_stall rises, and no item is lost.
// Configuration: write registers through cfg_write_en / cfg_index / cfg_data
// while no item is in flight.
// Reset: configuration returns to its defaults, all slot readings and turn
// counts clear to zero and the pipeline empties.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_feedback_multiturn_tracker import mft_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write_en,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      source_bus,
	input  logic [ID_W-1:0]           frame_id,
	input  logic [PAYLOAD_W-1:0]      frame_payload,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      result_bus,
	output logic [SLOT_W-1:0]         result_slot,
	output logic [ENC_W-1:0]          encoder_position,
	output logic signed [WORD_W-1:0]  motor_speed,
	output logic signed [WORD_W-1:0]  motor_current,
	output logic [BYTE_W-1:0]         motor_temperature,
	output logic signed [TURN_W-1:0]  turn_total,
	output logic signed [ANGLE_W-1:0] angle_degrees
);

	cfg_t               cfg;
	logic               v_s1;
	frame_t             frame_s1;
	logic               unwrap_ready;
	logic               unwrap_valid;
	unwrap_t            unwrap_item;
	logic               angle_ready;
	fields_t            res_fields;
	logic [ANGLE_W-1:0] res_angle;
	logic               in_ready;

	mft_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	// Capture the input item
	assign in_ready = !v_s1 || unwrap_ready;
	assign in_stall = !in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			frame_s1.bus     <= source_bus;
			frame_s1.id      <= frame_id;
			frame_s1.payload <= frame_payload;
		end
	end

	mft_unwrap u_unwrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (v_s1),
		.in_frame  (frame_s1),
		.in_ready  (unwrap_ready),
		.out_valid (unwrap_valid),
		.out_item  (unwrap_item),
		.out_ready (angle_ready)
	);

	mft_angle u_angle (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (unwrap_valid),
		.in_item    (unwrap_item),
		.in_ready   (angle_ready),
		.out_valid  (out_valid),
		.out_fields (res_fields),
		.out_angle  (res_angle),
		.out_ready  (!out_stall)
	);

	// Drive the result ports
	assign result_bus        = res_fields.bus;
	assign result_slot       = res_fields.slot;
	assign encoder_position  = res_fields.encoder;
	assign motor_speed       = res_fields.speed;
	assign motor_current     = res_fields.current;
	assign motor_temperature = res_fields.temperature;
	assign turn_total        = res_fields.turns;
	assign angle_degrees     = res_angle;

endmodule

`default_nettype wire
